// File: src/mhf_pkg.sv
// ============================================================================
// Multicast hash filter package
// Widths, CRC constants and the hash result type shared by the filter builder.
// ============================================================================
`default_nettype none

package mhf_pkg;

    localparam int ADDR_W  = 48;
    localparam int CRC_W   = 32;
    localparam int IDX_W   = 6;
    localparam int TABLE_W = 64;
    localparam int IDX_LSB = 23;

    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;

    typedef logic [ADDR_W-1:0][CRC_W-1:0] crc_cols_t;

    // Hash outcome of one address, handed from the hash logic to the table.
    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [IDX_W-1:0] idx;
        logic             applied;
    } hash_res_t;

    // Bit-serial CRC, used at elaboration only to build the constant columns.
    // Address bit i is bit (i mod 8) of byte (i / 8), so taking the bits in
    // ascending order follows the byte order and the LSB-first bit order.
    function automatic logic [CRC_W-1:0] crc_serial(input logic [ADDR_W-1:0] addr,
                                                    input logic [CRC_W-1:0]  init);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = init;
        for (int i = 0; i < ADDR_W; i++) begin
            fb  = crc[CRC_W-1] ^ addr[i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Contribution of each single address bit with a zero preset.
    function automatic crc_cols_t build_cols();
        crc_cols_t        cols;
        logic [ADDR_W-1:0] unit;
        for (int i = 0; i < ADDR_W; i++) begin
            unit    = '0;
            unit[i] = 1'b1;
            cols[i] = crc_serial(unit, '0);
        end
        return cols;
    endfunction

    localparam crc_cols_t        CRC_COLS = build_cols();
    localparam logic [CRC_W-1:0] CRC_BASE = crc_serial('0, CRC_PRESET);

    // The CRC is linear: the preset term XORed with the column of every set
    // address bit. The terms are independent, so this is a flat XOR tree.
    function automatic logic [CRC_W-1:0] crc_calc(input logic [ADDR_W-1:0] addr);
        logic [CRC_W-1:0] acc;
        acc = CRC_BASE;
        for (int i = 0; i < ADDR_W; i++) begin
            acc = acc ^ (CRC_COLS[i] & {CRC_W{addr[i]}});
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: src/mhf_if.sv
// ============================================================================
// Multicast hash filter channels
// Valid/ready channels for address beats in and result beats out.
// ============================================================================
`default_nettype none

interface mhf_item_if;
    import mhf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] mac_addr;
    logic              entry_valid;
    logic              clear_first;

    modport source (output valid, mac_addr, entry_valid, clear_first, input ready);
    modport sink   (input valid, mac_addr, entry_valid, clear_first, output ready);
endinterface

interface mhf_result_if;
    import mhf_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   hash_index;
    logic [CRC_W-1:0]   crc_value;
    logic               index_applied;
    logic [TABLE_W-1:0] hash_bits;

    modport source (output valid, hash_index, crc_value, index_applied, hash_bits,
                    input ready);
    modport sink   (input valid, hash_index, crc_value, index_applied, hash_bits,
                    output ready);
endinterface

`default_nettype wire

// File: src/mhf_hash.sv
// ============================================================================
// Multicast hash filter address hash
// CRC-32 of a registered address and the table index taken from it.
// ============================================================================
`default_nettype none

module mhf_hash (
    input  wire logic [mhf_pkg::ADDR_W-1:0] mac_addr,
    input  wire logic                       entry_valid,
    output mhf_pkg::hash_res_t              res
);
    import mhf_pkg::*;

    logic [CRC_W-1:0] crc;

    assign crc = crc_calc(mac_addr);

    // An unused entry reports zero CRC and index.
    always_comb
    begin
        res.applied = entry_valid;
        res.crc     = entry_valid ? crc : '0;
        res.idx     = entry_valid ? crc[IDX_LSB +: IDX_W] : '0;
    end

endmodule

`default_nettype wire

// File: src/mhf_table.sv
// ============================================================================
// Multicast hash filter table and result register
// Keeps the 64-bit table and holds each result beat until it is taken.
// ============================================================================
`default_nettype none

module mhf_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic               clear_first,
    input  wire mhf_pkg::hash_res_t res,
    output logic                    load_ok,
    mhf_result_if.source            result
);
    import mhf_pkg::*;

    logic [TABLE_W-1:0] table_reg;
    logic [TABLE_W-1:0] table_next;
    logic               valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CRC_W-1:0]   crc_reg;
    logic               applied_reg;
    logic [TABLE_W-1:0] bits_reg;

    assign load_ok = !valid_reg || result.ready;

    always_comb
    begin
        table_next = clear_first ? '0 : table_reg;
        if (res.applied) begin
            table_next[res.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            table_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                table_reg <= table_next;
                valid_reg <= 1'b1;
            end else if (result.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            idx_reg     <= res.idx;
            crc_reg     <= res.crc;
            applied_reg <= res.applied;
            bits_reg    <= table_next;
        end
    end

    assign result.valid         = valid_reg;
    assign result.hash_index    = idx_reg;
    assign result.crc_value     = crc_reg;
    assign result.index_applied = applied_reg;
    assign result.hash_bits     = bits_reg;

endmodule

`default_nettype wire

// File: src/multicast_hash_filter_builder.sv
// ============================================================================
// Multicast hash filter builder
// Hashes MAC addresses into the 64-bit multicast hash table of a receive
// filter, one address beat per cycle while the result receiver keeps ready high.
// ============================================================================
// Usage:
//   The item channel takes one beat per filter entry: a 48-bit address with
//   byte 0 in bits 7:0, a flag marking the entry as in use and a flag that
//   clears the table before the entry is applied. The result channel returns
//   exactly one beat per item: the table index (CRC bits 28:23), the CRC-32
//   of the address without final inversion, whether a bit was set, and the
//   whole table as it stands after the item.
//   An accepted beat is held in the input register while the CRC (a flat
//   XOR tree of constant columns) and the table update are worked out;
//   the result register loads them once it is free. The result beat thus
//   passes the input register and then the result register before it is
//   shown, and the block sustains one beat per cycle while the receiver
//   keeps ready high.
//   Reset clears the table to all zeros and empties both register stages.
//   When the receiver stalls, the result beat is held unchanged; the input
//   register still takes one more beat, after which ready drops until the
//   result register is freed.
// ============================================================================
`default_nettype none

module multicast_hash_filter_builder (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mhf_item_if.sink     item,
    mhf_result_if.source result
);
    import mhf_pkg::*;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_entry_reg;
    logic              s1_clear_reg;
    hash_res_t         hash_res;
    logic              load_ok;
    logic              advance;

    // The stage moves on whenever the result register can take its beat.
    assign advance    = s1_valid_reg && load_ok;
    assign item.ready = !s1_valid_reg || load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (item.ready) begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready) begin
            s1_addr_reg  <= item.mac_addr;
            s1_entry_reg <= item.entry_valid;
            s1_clear_reg <= item.clear_first;
        end
    end

    mhf_hash u_hash (
        .mac_addr    (s1_addr_reg),
        .entry_valid (s1_entry_reg),
        .res         (hash_res)
    );

    // The table is updated in the same edge that loads the result register,
    // so consecutive beats see each other's bits.
    mhf_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .clear_first (s1_clear_reg),
        .res         (hash_res),
        .load_ok     (load_ok),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: src/mhf_checker.sv
// ============================================================================
// Multicast hash filter checker
// Port-level assertions on the result channel of the filter builder.
// ============================================================================
`default_nettype none

module mhf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [mhf_pkg::IDX_W-1:0]   hash_index,
    input wire logic [mhf_pkg::CRC_W-1:0]   crc_value,
    input wire logic                        index_applied,
    input wire logic [mhf_pkg::TABLE_W-1:0] hash_bits
);
    import mhf_pkg::*;

    // A stalled result beat stays and keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_index)
            && $stable(crc_value) && $stable(index_applied) && $stable(hash_bits))
        else $error("result beat changed while stalled");

    // The reported index is the slice of the reported CRC.
    a_index_slice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_applied |-> hash_index == crc_value[IDX_LSB +: IDX_W])
        else $error("hash index does not match CRC bits");

    // A hashed entry's bit is present in the table it reports.
    a_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_applied |-> hash_bits[hash_index])
        else $error("table bit of applied entry not set");

    // An unused entry reports zero CRC and index.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_applied |-> crc_value == '0 && hash_index == '0)
        else $error("unused entry reported a non-zero hash");

endmodule

bind multicast_hash_filter_builder mhf_checker u_mhf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .hash_index    (result.hash_index),
    .crc_value     (result.crc_value),
    .index_applied (result.index_applied),
    .hash_bits     (result.hash_bits)
);

`default_nettype wire
